// File: hw/rtl/rmth_pkg.sv
// Package for the running median core: state codes, heap select and phase codes, field widths.
// No dependencies.
package rmth_pkg;

   localparam int SAMPLE_W = 32;
   localparam int MEDIAN_W = 33;
   localparam int HELD_W   = 11;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PUSH_RD,
      ST_PUSH_CMP,
      ST_POP_RD,
      ST_POP_LAST,
      ST_DN_CHK,
      ST_DN_RL,
      ST_DN_RR,
      ST_RESULT
   } state_type;

   typedef enum logic {
      HEAP_LO = 1'b0,
      HEAP_HI = 1'b1
   } heap_sel_type;

   typedef enum logic {
      PH_INSERT = 1'b0,
      PH_MOVE   = 1'b1
   } phase_type;

endpackage

// File: hw/rtl/running_median_two_heaps_core.sv
// Running median core: max-heap of the lower half, min-heap of the upper half,
// each in a synchronous memory with registered read data. Depends on rmth_pkg.
//
//   channel | dir | payload
//   req     | in  | tdata[31:0] sample
//   rsp     | out | tdata[32:0] median_doubled, [43:33] samples_held; tuser full_res
//
// One request at a time. A sift-up level passes ST_PUSH_RD and ST_PUSH_CMP; a sift-down
// level passes ST_DN_CHK, ST_DN_RL and ST_DN_RR. A request when full goes straight to the
// result; else it is pushed, and a rebalance adds a pop, a sift-down and a second push.
// Reset clears sizes and the last median; heap contents stay undefined.
// A result waits in the output register while rsp_tready is low.
module running_median_two_heaps_core #(
   parameter int CAPACITY = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] sample
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [32:0] median_doubled, [43:33] samples_held, zero pad
   output logic        rsp_tuser    // [0] full_res
);
   import rmth_pkg::*;

   localparam int DEPTH = CAPACITY / 2 + 1;
   localparam int AW    = $clog2(DEPTH);
   localparam int SW    = $clog2(DEPTH + 1);
   localparam int CW    = SW + 1;
   localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

   logic [SAMPLE_W-1:0] lo_mem [DEPTH];
   logic [SAMPLE_W-1:0] hi_mem [DEPTH];
   logic [SAMPLE_W-1:0] lo_rd_ff, hi_rd_ff, rdata;

   state_type    state_ff, state_in;
   heap_sel_type sel_ff, sel_in;
   phase_type    phase_ff, phase_in;
   logic [SW-1:0] lo_size_ff, lo_size_in, hi_size_ff, hi_size_in, n_ff, n_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic signed [SAMPLE_W-1:0] val_ff, val_in, mov_ff, mov_in, cl_ff, cl_in;
   logic signed [SAMPLE_W-1:0] lo_top_ff, hi_top_ff;
   logic full_ff, full_in;
   logic signed [MEDIAN_W-1:0] last_ff, last_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [47:0] rsp_data_ff, rsp_data_in;
   logic rsp_user_ff, rsp_user_in;

   logic          mem_we;
   logic [AW-1:0] mem_waddr, mem_raddr;
   logic [SAMPLE_W-1:0] mem_wdata;

   logic [CW-1:0]   held;
   logic [AW-1:0]   parent;
   logic [AW+1:0]   lch, rch;
   logic            l_ok, r_ok, best_l, best_r;
   logic signed [SAMPLE_W-1:0] bv;
   logic [31:0]     held32;
   logic            accept;

   function automatic logic above(input heap_sel_type s, input logic signed [31:0] a,
                                  input logic signed [31:0] b);
      return (s == HEAP_LO) ? (a > b) : (a < b);
   endfunction

   assign held    = CW'(lo_size_ff) + CW'(hi_size_ff);
   assign parent  = (idx_ff - AW'(1)) >> 1;
   assign lch     = {1'b0, idx_ff, 1'b1};
   assign rch     = lch + (AW+2)'(1);
   assign l_ok    = lch < (AW+2)'(n_ff);
   assign r_ok    = rch < (AW+2)'(n_ff);
   assign rdata   = (sel_ff == HEAP_LO) ? lo_rd_ff : hi_rd_ff;
   assign best_l  = above(sel_ff, cl_ff, val_ff);
   assign bv      = best_l ? cl_ff : val_ff;
   assign best_r  = r_ok && above(sel_ff, rdata, bv);
   assign accept  = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   always_ff @(posedge clock) begin
      if (mem_we && sel_ff == HEAP_LO) lo_mem[mem_waddr] <= mem_wdata;
      if (mem_we && sel_ff == HEAP_HI) hi_mem[mem_waddr] <= mem_wdata;
      lo_rd_ff <= lo_mem[mem_raddr];
      hi_rd_ff <= hi_mem[mem_raddr];
      if (mem_we && mem_waddr == '0) begin
         if (sel_ff == HEAP_LO) lo_top_ff <= mem_wdata;
         else                   hi_top_ff <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         lo_size_ff   <= '0;
         hi_size_ff   <= '0;
         last_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         lo_size_ff   <= lo_size_in;
         hi_size_ff   <= hi_size_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sel_ff      <= sel_in;
      phase_ff    <= phase_in;
      n_ff        <= n_in;
      idx_ff      <= idx_in;
      val_ff      <= val_in;
      mov_ff      <= mov_in;
      cl_ff       <= cl_in;
      full_ff     <= full_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   always_comb begin
      state_in     = state_ff;
      sel_in       = sel_ff;
      phase_in     = phase_ff;
      lo_size_in   = lo_size_ff;
      hi_size_in   = hi_size_ff;
      n_in         = n_ff;
      idx_in       = idx_ff;
      val_in       = val_ff;
      mov_in       = mov_ff;
      cl_in        = cl_ff;
      full_in      = full_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      mem_we       = 1'b0;
      mem_waddr    = idx_ff;
      mem_wdata    = val_ff;
      mem_raddr    = idx_ff;
      held32       = 32'(held);

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               val_in   = req_tdata;
               phase_in = PH_INSERT;
               if (held >= CAP_C) begin
                  full_in  = 1'b1;
                  state_in = ST_RESULT;
               end else begin
                  full_in  = 1'b0;
                  state_in = ST_PUSH_RD;
                  if (lo_size_ff == '0 || $signed(req_tdata) < lo_top_ff) begin
                     sel_in     = HEAP_LO;
                     idx_in     = AW'(lo_size_ff);
                     lo_size_in = lo_size_ff + SW'(1);
                  end else begin
                     sel_in     = HEAP_HI;
                     idx_in     = AW'(hi_size_ff);
                     hi_size_in = hi_size_ff + SW'(1);
                  end
               end
            end
         end
         ST_PUSH_RD: begin
            if (idx_ff == '0) begin
               mem_we = 1'b1;
               if (phase_ff == PH_MOVE) begin
                  state_in = ST_RESULT;
               end else if (lo_size_ff >= hi_size_ff + SW'(2)) begin
                  sel_in   = HEAP_LO;
                  state_in = ST_POP_RD;
               end else if (hi_size_ff >= lo_size_ff + SW'(2)) begin
                  sel_in   = HEAP_HI;
                  state_in = ST_POP_RD;
               end else begin
                  state_in = ST_RESULT;
               end
            end else begin
               mem_raddr = parent;
               state_in  = ST_PUSH_CMP;
            end
         end
         ST_PUSH_CMP: begin
            mem_we = 1'b1;
            if (above(sel_ff, val_ff, rdata)) begin
               mem_wdata = rdata;
               idx_in    = parent;
            end
            state_in = ST_PUSH_RD;
            if (!above(sel_ff, val_ff, rdata)) begin
               idx_in = '0;
               mem_waddr = idx_ff;
               if (phase_ff == PH_MOVE) begin
                  state_in = ST_RESULT;
               end else if (lo_size_ff >= hi_size_ff + SW'(2)) begin
                  sel_in   = HEAP_LO;
                  state_in = ST_POP_RD;
               end else if (hi_size_ff >= lo_size_ff + SW'(2)) begin
                  sel_in   = HEAP_HI;
                  state_in = ST_POP_RD;
               end else begin
                  state_in = ST_RESULT;
               end
            end
         end
         ST_POP_RD: begin
            if (sel_ff == HEAP_LO) begin
               n_in       = lo_size_ff - SW'(1);
               lo_size_in = lo_size_ff - SW'(1);
               mov_in     = lo_top_ff;
               mem_raddr  = AW'(lo_size_ff - SW'(1));
            end else begin
               n_in       = hi_size_ff - SW'(1);
               hi_size_in = hi_size_ff - SW'(1);
               mov_in     = hi_top_ff;
               mem_raddr  = AW'(hi_size_ff - SW'(1));
            end
            state_in = ST_POP_LAST;
         end
         ST_POP_LAST: begin
            val_in   = rdata;
            idx_in   = '0;
            state_in = ST_DN_CHK;
         end
         ST_DN_CHK: begin
            if (l_ok) begin
               mem_raddr = lch[AW-1:0];
               state_in  = ST_DN_RL;
            end else begin
               mem_we = 1'b1;
               state_in = ST_PUSH_RD;
               phase_in = PH_MOVE;
               val_in   = mov_ff;
               if (sel_ff == HEAP_LO) begin
                  sel_in     = HEAP_HI;
                  idx_in     = AW'(hi_size_ff);
                  hi_size_in = hi_size_ff + SW'(1);
               end else begin
                  sel_in     = HEAP_LO;
                  idx_in     = AW'(lo_size_ff);
                  lo_size_in = lo_size_ff + SW'(1);
               end
            end
         end
         ST_DN_RL: begin
            cl_in     = rdata;
            mem_raddr = r_ok ? rch[AW-1:0] : lch[AW-1:0];
            state_in  = ST_DN_RR;
         end
         ST_DN_RR: begin
            mem_we   = 1'b1;
            state_in = ST_DN_CHK;
            if (best_r) begin
               mem_wdata = rdata;
               idx_in    = rch[AW-1:0];
            end else if (best_l) begin
               mem_wdata = cl_ff;
               idx_in    = lch[AW-1:0];
            end else begin
               state_in = ST_PUSH_RD;
               phase_in = PH_MOVE;
               val_in   = mov_ff;
               if (sel_ff == HEAP_LO) begin
                  sel_in     = HEAP_HI;
                  idx_in     = AW'(hi_size_ff);
                  hi_size_in = hi_size_ff + SW'(1);
               end else begin
                  sel_in     = HEAP_LO;
                  idx_in     = AW'(lo_size_ff);
                  lo_size_in = lo_size_ff + SW'(1);
               end
            end
         end
         ST_RESULT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               if (!full_ff) begin
                  if (lo_size_ff == hi_size_ff)
                     last_in = MEDIAN_W'(lo_top_ff) + MEDIAN_W'(hi_top_ff);
                  else if (lo_size_ff > hi_size_ff)
                     last_in = {lo_top_ff, 1'b0};
                  else
                     last_in = {hi_top_ff, 1'b0};
               end
               rsp_valid_in = 1'b1;
               rsp_data_in  = {4'b0, held32[HELD_W-1:0], last_in};
               rsp_user_in  = full_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

// File: hw/rtl/rmth_chk.sv
// Port-level checker for the running median core, bound to the top level.
// Depends on rmth_pkg only through the top level's port widths.
module rmth_chk #(
   parameter int CAPACITY = 1024
) (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata,
   input logic        rsp_tuser
);
   localparam logic [10:0] CAP_LOW = 11'(CAPACITY);

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[43:33] == CAP_LOW)
      else $error("full result with wrong held count");

   a_one_req: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second request taken while busy");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   a_first_med: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser && rsp_tdata[43:33] == 11'd1 |->
      rsp_tdata[0] == 1'b0)
      else $error("single-sample median not even");

endmodule

bind running_median_two_heaps_core rmth_chk #(.CAPACITY(CAPACITY)) u_rmth_chk (.*);
